// ===== hdl/hevc_rtp_packetizer_defines.svh =====
// assertion macros shared by the packetizer modules
// no dependencies; each user module must have clk and rst_n in scope
`ifndef HEVC_RTP_PACKETIZER_DEFINES_SVH
`define HEVC_RTP_PACKETIZER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define HRTP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define HRTP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/hrtp_pkg.sv =====
// shared types and constants of the hevc rtp packetizer
// no dependencies
package hrtp_pkg;

    // default width of the nalu size field
    localparam int SIZE_BITS_DEF = 24;

    // configuration register indexes
    localparam int CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAYLOAD_TYPE = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SSRC         = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SEQ_START    = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PAYLOAD  = 8'd3;

    // register reset values
    localparam logic [6:0]  PT_RESET   = 7'd96;
    localparam logic [15:0] MAXP_RESET = 16'd1388;

    // packet constants
    localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
    localparam logic [7:0] FU_TYPE_BYTE     = 8'(49 << 1);
    localparam logic [7:0] FU_SECOND_BYTE   = 8'h01;
    localparam logic [5:0] NAL_TYPE_MASK    = 6'h3f;
    localparam logic [7:0] FU_START_BIT     = 8'h80;
    localparam logic [7:0] FU_END_BIT       = 8'h40;
    localparam logic [15:0] FU_HDR_OVERHEAD = 16'd3;

    // byte positions within the emitted sequence of one command
    typedef logic [3:0] step_t;
    localparam step_t STEP_FIRST    = 4'd0;
    localparam step_t STEP_HDR_LAST = 4'd11;
    localparam step_t STEP_DATA     = 4'd15;

    // command queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // what the back end emits for one input byte
    typedef enum logic [1:0] {
        CMD_DATA,
        CMD_SINGLE,
        CMD_FRAG
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic        marker;
        logic [15:0] seq;
        logic [31:0] timestamp;
        logic [7:0]  fu_byte;
        logic [7:0]  data;
        logic        data_end;
    } cmd_t;

    // register values seen by front and back
    typedef struct packed {
        logic [6:0]  payload_type;
        logic [31:0] ssrc;
        logic [15:0] max_payload;
    } cfg_t;

    // sequence counter load request
    typedef struct packed {
        logic        load;
        logic [15:0] value;
    } seq_load_t;

endpackage

// ===== hdl/hevc_rtp_packetizer.sv =====
// top level of the hevc rtp packetizer: register file and part wiring
// depends on hrtp_pkg, hrtp_front, hrtp_queue and hrtp_back

// Takes one NAL unit byte per transfer and emits the RTP byte stream, one
// byte per output transfer. The first byte of a NALU brings its size and
// timestamp; a NALU no larger than max_payload becomes one packet with the
// marker set, a larger one becomes fragmentation units. An input byte causes
// 0, 1, 13 or 16 output bytes and the back end emits one per cycle unless
// out_ready holds it back: 1 byte for a payload byte, 13 for a single-NALU
// packet start and 16 for a fragment start. The two header bytes of a
// fragmented NALU produce nothing.
// A four-entry command queue lets the input keep streaming while a header
// burst drains. Register writes are taken every cycle (cfg_ready is high)
// and are meant for idle periods.
module hevc_rtp_packetizer #(
    parameter int SIZE_BITS = hrtp_pkg::SIZE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       nal_byte,
    input  logic [SIZE_BITS-1:0]             nalu_size,
    input  logic [31:0]                      time_stamp,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [7:0]                       out_byte,
    output logic                             packet_end,
    output logic                             run_last,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [hrtp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                      cfg_data
);

    hrtp_pkg::cfg_t      cfg_reg;
    hrtp_pkg::seq_load_t seq_load;
    logic                cfg_write;
    logic                push;
    hrtp_pkg::cmd_t      push_cmd;
    logic                q_full;
    logic                q_valid;
    hrtp_pkg::cmd_t      q_cmd;
    logic                pop;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // sequence start write loads the counter in the front end
    assign seq_load.load  = cfg_write && (cfg_index == hrtp_pkg::CFG_SEQ_START);
    assign seq_load.value = cfg_data[15:0];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.payload_type <= hrtp_pkg::PT_RESET;
            cfg_reg.ssrc         <= '0;
            cfg_reg.max_payload  <= hrtp_pkg::MAXP_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                hrtp_pkg::CFG_PAYLOAD_TYPE: cfg_reg.payload_type <= cfg_data[6:0];
                hrtp_pkg::CFG_SSRC:         cfg_reg.ssrc         <= cfg_data;
                hrtp_pkg::CFG_MAX_PAYLOAD:  cfg_reg.max_payload  <= cfg_data[15:0];
                default:                    cfg_reg              <= cfg_reg;
            endcase
        end
    end

    hrtp_front #(
        .SIZE_BITS (SIZE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .nal_byte   (nal_byte),
        .nalu_size  (nalu_size),
        .time_stamp (time_stamp),
        .cfg        (cfg_reg),
        .seq_load   (seq_load),
        .push       (push),
        .push_cmd   (push_cmd),
        .q_full     (q_full)
    );

    hrtp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    hrtp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_valid    (q_valid),
        .q_cmd      (q_cmd),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .packet_end (packet_end),
        .run_last   (run_last)
    );

endmodule

// ===== hdl/hrtp_front.sv =====
// front end: takes nal bytes, tracks nalu and fragment state, builds commands
// depends on hrtp_pkg and hevc_rtp_packetizer_defines.svh
`include "hevc_rtp_packetizer_defines.svh"

module hrtp_front #(
    parameter int SIZE_BITS = hrtp_pkg::SIZE_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           nal_byte,
    input  logic [SIZE_BITS-1:0] nalu_size,
    input  logic [31:0]          time_stamp,
    input  hrtp_pkg::cfg_t       cfg,
    input  hrtp_pkg::seq_load_t  seq_load,
    output logic                 push,
    output hrtp_pkg::cmd_t       push_cmd,
    input  logic                 q_full
);

    logic [SIZE_BITS-1:0] bytes_left_reg, bytes_left_next;
    logic [15:0]          fragment_left_reg, fragment_left_next;
    logic                 fragmenting_reg, fragmenting_next;
    logic                 first_fragment_reg, first_fragment_next;
    logic [5:0]           held_type_reg, held_type_next;
    logic [31:0]          held_ts_reg, held_ts_next;
    logic [1:0]           byte_index_reg, byte_index_next;
    logic [15:0]          seq_reg, seq_next;

    logic                 accept;
    logic                 new_nalu;
    logic [SIZE_BITS-1:0] size_eff;
    logic [SIZE_BITS-1:0] left_eff;
    logic [SIZE_BITS-1:0] left_dec;
    logic                 frag_eff;
    logic [31:0]          ts_eff;
    logic [5:0]           type_eff;
    logic [1:0]           index_eff;
    logic [15:0]          frag_left_eff;
    logic                 first_eff;
    logic [15:0]          fsize;
    logic                 is_end;
    logic [15:0]          frag_left_new;
    logic                 uses_header;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // values as seen by this byte, with a new nalu starting fresh
    always_comb
    begin
        new_nalu      = (bytes_left_reg == '0);
        size_eff      = (nalu_size == '0) ? SIZE_BITS'(1) : nalu_size;
        left_eff      = new_nalu ? size_eff : bytes_left_reg;
        left_dec      = left_eff - SIZE_BITS'(1);
        frag_eff      = new_nalu ? (size_eff > SIZE_BITS'(cfg.max_payload)) : fragmenting_reg;
        ts_eff        = new_nalu ? time_stamp : held_ts_reg;
        type_eff      = new_nalu ? (nal_byte[6:1] & hrtp_pkg::NAL_TYPE_MASK) : held_type_reg;
        index_eff     = new_nalu ? 2'd0 : byte_index_reg;
        frag_left_eff = new_nalu ? 16'd0 : fragment_left_reg;
        first_eff     = new_nalu ? 1'b1 : first_fragment_reg;
    end

    // fragment sizing and command build
    always_comb
    begin
        fsize = (cfg.max_payload > hrtp_pkg::FU_HDR_OVERHEAD)
              ? (cfg.max_payload - hrtp_pkg::FU_HDR_OVERHEAD) : 16'd1;
        is_end = (SIZE_BITS'(fsize) >= left_eff);
        frag_left_new = frag_left_eff;
        push_cmd = '0;
        push_cmd.seq       = seq_reg;
        push_cmd.timestamp = ts_eff;
        push_cmd.data      = nal_byte;
        push_cmd.kind      = hrtp_pkg::CMD_DATA;
        push = 1'b0;
        uses_header = 1'b0;
        if (!frag_eff)
        begin
            push = accept;
            push_cmd.kind     = new_nalu ? hrtp_pkg::CMD_SINGLE : hrtp_pkg::CMD_DATA;
            push_cmd.marker   = 1'b1;
            push_cmd.data_end = (left_eff == SIZE_BITS'(1));
            uses_header       = new_nalu;
        end
        else if (index_eff == 2'd2)
        begin
            push = accept;
            if (frag_left_eff == 16'd0)
            begin
                push_cmd.kind    = hrtp_pkg::CMD_FRAG;
                push_cmd.marker  = is_end;
                push_cmd.fu_byte = {2'b00, type_eff}
                                 | (first_eff ? hrtp_pkg::FU_START_BIT : 8'h00)
                                 | (is_end ? hrtp_pkg::FU_END_BIT : 8'h00);
                frag_left_new = (is_end ? left_eff[15:0] : fsize) - 16'd1;
                uses_header   = 1'b1;
            end
            else
            begin
                frag_left_new = frag_left_eff - 16'd1;
            end
            push_cmd.data_end = (frag_left_new == 16'd0);
        end
    end

    // next state
    always_comb
    begin
        bytes_left_next     = bytes_left_reg;
        fragment_left_next  = fragment_left_reg;
        fragmenting_next    = fragmenting_reg;
        first_fragment_next = first_fragment_reg;
        held_type_next      = held_type_reg;
        held_ts_next        = held_ts_reg;
        byte_index_next     = byte_index_reg;
        seq_next            = seq_reg;
        if (seq_load.load)
        begin
            seq_next = seq_load.value;
        end
        if (accept)
        begin
            bytes_left_next     = left_dec;
            fragment_left_next  = (left_dec == '0) ? 16'd0 : frag_left_new;
            fragmenting_next    = frag_eff;
            first_fragment_next = first_eff && !(push && uses_header && frag_eff);
            held_type_next      = new_nalu && frag_eff ? type_eff : held_type_reg;
            held_ts_next        = ts_eff;
            byte_index_next     = (index_eff == 2'd2) ? 2'd2 : index_eff + 2'd1;
            if (push && uses_header)
            begin
                seq_next = seq_reg + 16'd1;
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg     <= '0;
            fragment_left_reg  <= '0;
            fragmenting_reg    <= 1'b0;
            first_fragment_reg <= 1'b1;
            held_type_reg      <= '0;
            held_ts_reg        <= '0;
            byte_index_reg     <= '0;
            seq_reg            <= '0;
        end
        else
        begin
            bytes_left_reg     <= bytes_left_next;
            fragment_left_reg  <= fragment_left_next;
            fragmenting_reg    <= fragmenting_next;
            first_fragment_reg <= first_fragment_next;
            held_type_reg      <= held_type_next;
            held_ts_reg        <= held_ts_next;
            byte_index_reg     <= byte_index_next;
            seq_reg            <= seq_next;
        end
    end

    // checks
    `HRTP_ASSERT_NOW(a_frag_left_only_fragmenting, fragment_left_reg != 16'd0,
        fragmenting_reg, "fragment count open outside a fragmented nalu")
    `HRTP_ASSERT_NOW(a_push_only_on_transfer, push, accept,
        "command pushed without an input transfer")

endmodule

// ===== hdl/hrtp_queue.sv =====
// short command queue between front and back end
// depends on hrtp_pkg and hevc_rtp_packetizer_defines.svh
`include "hevc_rtp_packetizer_defines.svh"

module hrtp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  hrtp_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           q_valid,
    output hrtp_pkg::cmd_t q_cmd
);

    hrtp_pkg::cmd_t mem [hrtp_pkg::QUEUE_DEPTH];

    logic [hrtp_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [hrtp_pkg::QCNT_W-1:0] count_reg;
    logic                        do_pop;

    assign full    = (count_reg == hrtp_pkg::QCNT_W'(hrtp_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_cmd   = mem[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // checks
    `HRTP_ASSERT_NOW(a_no_push_when_full, push, !full, "push into a full queue")
    `HRTP_ASSERT_NOW(a_count_in_range,
        1'b1, count_reg <= hrtp_pkg::QCNT_W'(hrtp_pkg::QUEUE_DEPTH),
        "queue count beyond depth")

endmodule

// ===== hdl/hrtp_back.sv =====
// back end: expands commands into rtp header, fu header and data bytes
// depends on hrtp_pkg and hevc_rtp_packetizer_defines.svh
`include "hevc_rtp_packetizer_defines.svh"

module hrtp_back (
    input  logic           clk,
    input  logic           rst_n,
    input  hrtp_pkg::cfg_t cfg,
    input  logic           q_valid,
    input  hrtp_pkg::cmd_t q_cmd,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     out_byte,
    output logic           packet_end,
    output logic           run_last
);

    hrtp_pkg::cmd_t  cur_reg;
    logic            cur_valid_reg;
    hrtp_pkg::step_t step_reg;
    logic            out_valid_reg;
    logic [7:0]      out_byte_reg;
    logic            packet_end_reg;
    logic            run_last_reg;

    logic            emit;
    logic            last;
    logic [7:0]      byte_sel;
    hrtp_pkg::step_t step_next;

    assign emit = cur_valid_reg && (!out_valid_reg || out_ready);
    assign last = (step_reg == hrtp_pkg::STEP_DATA);
    assign pop  = q_valid && (!cur_valid_reg || (emit && last));

    // byte for the current position
    always_comb
    begin
        case (step_reg)
            4'd0:    byte_sel = hrtp_pkg::RTP_VERSION_BYTE;
            4'd1:    byte_sel = {cur_reg.marker, cfg.payload_type};
            4'd2:    byte_sel = cur_reg.seq[15:8];
            4'd3:    byte_sel = cur_reg.seq[7:0];
            4'd4:    byte_sel = cur_reg.timestamp[31:24];
            4'd5:    byte_sel = cur_reg.timestamp[23:16];
            4'd6:    byte_sel = cur_reg.timestamp[15:8];
            4'd7:    byte_sel = cur_reg.timestamp[7:0];
            4'd8:    byte_sel = cfg.ssrc[31:24];
            4'd9:    byte_sel = cfg.ssrc[23:16];
            4'd10:   byte_sel = cfg.ssrc[15:8];
            4'd11:   byte_sel = cfg.ssrc[7:0];
            4'd12:   byte_sel = hrtp_pkg::FU_TYPE_BYTE;
            4'd13:   byte_sel = hrtp_pkg::FU_SECOND_BYTE;
            4'd14:   byte_sel = cur_reg.fu_byte;
            default: byte_sel = cur_reg.data;
        endcase
    end

    // single nal packets skip the fu header
    always_comb
    begin
        if (step_reg == hrtp_pkg::STEP_HDR_LAST && cur_reg.kind == hrtp_pkg::CMD_SINGLE)
        begin
            step_next = hrtp_pkg::STEP_DATA;
        end
        else
        begin
            step_next = step_reg + 4'd1;
        end
    end

    // command register load
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= q_cmd;
        end
    end

    // sequencing control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            step_reg      <= hrtp_pkg::STEP_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                cur_valid_reg <= 1'b1;
                step_reg      <= (q_cmd.kind == hrtp_pkg::CMD_DATA)
                               ? hrtp_pkg::STEP_DATA : hrtp_pkg::STEP_FIRST;
            end
            else if (emit && last)
            begin
                cur_valid_reg <= 1'b0;
            end
            else if (emit)
            begin
                step_reg <= step_next;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg   <= byte_sel;
            packet_end_reg <= last && cur_reg.data_end;
            run_last_reg   <= last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign packet_end = packet_end_reg;
    assign run_last   = run_last_reg;

    // checks
    `HRTP_ASSERT_NOW(a_data_cmd_at_data_step,
        cur_valid_reg && cur_reg.kind == hrtp_pkg::CMD_DATA,
        step_reg == hrtp_pkg::STEP_DATA, "data-only command not at data position")
    `HRTP_ASSERT_NEXT(a_end_marks_run_last, emit && last && cur_reg.data_end,
        out_valid_reg && packet_end_reg && run_last_reg,
        "packet end not flagged on the data byte")

endmodule

// ===== verif/hrtp_stream_checker.sv =====
// stream checker for the hevc rtp packetizer: predicts and compares the rtp byte stream
// depends on hrtp_pkg; instantiated beside the block by tb_top
module hrtp_stream_checker #(
    parameter int SIZE_BITS = hrtp_pkg::SIZE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic [7:0]                       nal_byte,
    input  logic [SIZE_BITS-1:0]             nalu_size,
    input  logic [31:0]                      time_stamp,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic [7:0]                       out_byte,
    input  logic                             packet_end,
    input  logic                             run_last,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [hrtp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                      cfg_data,
    output int                               errors,
    output int                               pending,
    output int                               packets
);

    import hrtp_pkg::*;

    localparam int MAX_PRINTED = 30;

    typedef struct packed {
        logic [7:0] data;
        logic       pkt_end;
        logic       last;
    } rtp_byte_t;

    // register copies
    logic [6:0]  cur_pt;
    logic [31:0] cur_ssrc;
    logic [15:0] cur_maxp;

    // packetizer state
    logic [15:0]          seq_cnt;
    logic [SIZE_BITS-1:0] nalu_left;
    logic [SIZE_BITS-1:0] nalu_pos;
    logic [15:0]          frag_left;
    logic                 in_frag;
    logic                 first_frag;
    logic [5:0]           nal_type;
    logic [31:0]          nalu_ts;

    rtp_byte_t expected_bytes[$];
    rtp_byte_t burst[$];

    task automatic report_mismatch(input string what);
        if (errors < MAX_PRINTED)
            $display("mismatch at %0t: %s", $time, what);
        errors++;
    endtask

    task automatic emit_byte(input logic [7:0] b, input logic e);
        rtp_byte_t item;
        item.data = b;
        item.pkt_end = e;
        item.last = 1'b0;
        burst.push_back(item);
    endtask

    // 12-byte rtp header, big-endian fields, bumps the sequence number
    task automatic emit_rtp_header(input logic marker);
        emit_byte(RTP_VERSION_BYTE, 1'b0);
        emit_byte({marker, cur_pt}, 1'b0);
        emit_byte(seq_cnt[15:8], 1'b0);
        emit_byte(seq_cnt[7:0], 1'b0);
        emit_byte(nalu_ts[31:24], 1'b0);
        emit_byte(nalu_ts[23:16], 1'b0);
        emit_byte(nalu_ts[15:8], 1'b0);
        emit_byte(nalu_ts[7:0], 1'b0);
        emit_byte(cur_ssrc[31:24], 1'b0);
        emit_byte(cur_ssrc[23:16], 1'b0);
        emit_byte(cur_ssrc[15:8], 1'b0);
        emit_byte(cur_ssrc[7:0], 1'b0);
        seq_cnt = seq_cnt + 16'd1;
    endtask

    // bytes that one accepted nal byte produces
    task automatic packetize_byte(input logic [7:0] b, input logic [SIZE_BITS-1:0] sz,
                                  input logic [31:0] ts);
        logic [SIZE_BITS-1:0] len;
        logic [31:0]          fsize;
        logic                 is_end;
        logic [7:0]           fu;
        burst.delete();

        // first byte of a nalu: latch size, timestamp and the single/fragment choice
        if (nalu_left == '0) begin
            len = (sz == '0) ? SIZE_BITS'(1) : sz;
            nalu_ts = ts;
            nalu_left = len;
            nalu_pos = '0;
            frag_left = '0;
            first_frag = 1'b1;
            in_frag = (len > cur_maxp);
            if (in_frag)
                nal_type = b[6:1] & NAL_TYPE_MASK;
            else
                emit_rtp_header(1'b1);
        end

        if (!in_frag) begin
            emit_byte(b, nalu_left == SIZE_BITS'(1));
        end else if (nalu_pos >= SIZE_BITS'(2)) begin
            // new fragment: rtp header plus fu header
            if (frag_left == '0) begin
                fsize = (cur_maxp > FU_HDR_OVERHEAD) ?
                        {16'd0, cur_maxp - FU_HDR_OVERHEAD} : 32'd1;
                is_end = 1'b0;
                if (fsize >= nalu_left) begin
                    fsize = 32'(nalu_left);
                    is_end = 1'b1;
                end
                emit_rtp_header(is_end);
                fu = {2'b00, nal_type & NAL_TYPE_MASK};
                if (first_frag)
                    fu = fu | FU_START_BIT;
                if (is_end)
                    fu = fu | FU_END_BIT;
                emit_byte(FU_TYPE_BYTE, 1'b0);
                emit_byte(FU_SECOND_BYTE, 1'b0);
                emit_byte(fu, 1'b0);
                frag_left = fsize[15:0];
                first_frag = 1'b0;
            end
            frag_left = frag_left - 16'd1;
            emit_byte(b, frag_left == '0);
        end

        nalu_left = nalu_left - SIZE_BITS'(1);
        if (nalu_pos != '1)
            nalu_pos = nalu_pos + SIZE_BITS'(1);
        if (nalu_left == '0)
            frag_left = '0;

        // flag the last byte of this burst
        for (int i = 0; i < burst.size(); i++) begin
            if (i == burst.size() - 1)
                burst[i].last = 1'b1;
            expected_bytes.push_back(burst[i]);
        end
    endtask

    task automatic apply_register(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
        case (idx)
            CFG_PAYLOAD_TYPE: cur_pt = data[6:0];
            CFG_SSRC:         cur_ssrc = data;
            CFG_SEQ_START:    seq_cnt = data[15:0];
            CFG_MAX_PAYLOAD:  cur_maxp = data[15:0];
            default:          ;
        endcase
    endtask

    task automatic check_output(input logic [7:0] b, input logic e, input logic l);
        rtp_byte_t want;
        if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h", b));
        end else begin
            want = expected_bytes.pop_front();
            if (b !== want.data)
                report_mismatch($sformatf("out_byte got %02h want %02h", b, want.data));
            if (e !== want.pkt_end)
                report_mismatch($sformatf("packet_end got %b want %b", e, want.pkt_end));
            if (l !== want.last)
                report_mismatch($sformatf("run_last got %b want %b", l, want.last));
            if (want.pkt_end)
                packets++;
        end
    endtask

    // watch the three channels: register writes, then input, then output
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cur_pt = PT_RESET;
            cur_ssrc = '0;
            cur_maxp = MAXP_RESET;
            seq_cnt = '0;
            nalu_left = '0;
            nalu_pos = '0;
            frag_left = '0;
            in_frag = 1'b0;
            first_frag = 1'b1;
            nal_type = '0;
            nalu_ts = '0;
            expected_bytes.delete();
            errors = 0;
            pending = 0;
            packets = 0;
        end else begin
            if (cfg_valid && cfg_ready)
                apply_register(cfg_index, cfg_data);
            if (in_valid && in_ready)
                packetize_byte(nal_byte, nalu_size, time_stamp);
            if (out_valid && out_ready)
                check_output(out_byte, packet_end, run_last);
            pending = expected_bytes.size();
        end
    end

endmodule

// ===== verif/tb_top.sv =====
// testbench top for the hevc rtp packetizer: stimulus, flow control and verdict
// depends on hrtp_pkg, hevc_rtp_packetizer and hrtp_stream_checker
module tb_top;

    localparam int SZ_W          = hrtp_pkg::SIZE_BITS_DEF;
    localparam int IDX_W         = hrtp_pkg::CFG_INDEX_W;
    localparam int SETTLE_CYCLES = 80;
    localparam int QUIET_LIMIT   = 2000;
    localparam int PHASES        = 8;
    localparam int PHASE_BYTES   = 10;
    localparam int MAX_LEN       = 20;

    // indexes with no register behind them
    localparam logic [IDX_W-1:0] CFG_UNUSED_FIRST = 8'd4;
    localparam logic [IDX_W-1:0] CFG_UNUSED_LAST  = 8'hFF;

    logic             clk;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [7:0]       nal_byte = '0;
    logic [SZ_W-1:0]  nalu_size = '0;
    logic [31:0]      time_stamp = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [7:0]       out_byte;
    logic             packet_end;
    logic             run_last;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [31:0]      cfg_data = '0;

    int errors;
    int pending;
    int packets;
    int send_idle = 0;
    int recv_stall = 0;
    int bytes_sent = 0;
    int settings_used = 0;
    int quiet_cycles = 0;

    hevc_rtp_packetizer #(.SIZE_BITS(SZ_W)) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .nal_byte   (nal_byte),
        .nalu_size  (nalu_size),
        .time_stamp (time_stamp),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .packet_end (packet_end),
        .run_last   (run_last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    hrtp_stream_checker #(.SIZE_BITS(SZ_W)) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .nal_byte   (nal_byte),
        .nalu_size  (nalu_size),
        .time_stamp (time_stamp),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .packet_end (packet_end),
        .run_last   (run_last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .errors     (errors),
        .pending    (pending),
        .packets    (packets)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // receiver back-pressure
    initial
    begin
        forever
        begin
            @(negedge clk);
            out_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // one nal byte transfer, with random idle cycles ahead of it
    task automatic send_nal_byte(input logic [7:0] b, input logic [SZ_W-1:0] sz,
                                 input logic [31:0] ts);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        nal_byte <= b;
        nalu_size <= sz;
        time_stamp <= ts;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    // bytes from..upto-1 of a nalu; only byte zero carries size and timestamp
    task automatic send_nalu_bytes(input int from, input int upto, input logic [SZ_W-1:0] sz,
                                   input logic [31:0] ts, input logic [7:0] hdr);
        for (int i = from; i < upto; i++)
        begin
            if (i == 0)
                send_nal_byte(hdr, sz, ts);
            else
                send_nal_byte(8'($urandom), SZ_W'($urandom), $urandom);
        end
    endtask

    // drop valid, wait for the stream to drain, then let zero-result bytes finish
    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [IDX_W-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // full register setting while idle, plus one write to an unused index
    task automatic program_regs(input logic [6:0] pt, input logic [31:0] ssrc,
                                input logic [15:0] seq, input logic [15:0] maxp,
                                input logic [IDX_W-1:0] junk_idx);
        settle();
        write_register(hrtp_pkg::CFG_PAYLOAD_TYPE, {25'd0, pt});
        write_register(hrtp_pkg::CFG_SSRC, ssrc);
        write_register(hrtp_pkg::CFG_SEQ_START, {16'd0, seq});
        write_register(junk_idx, $urandom);
        write_register(hrtp_pkg::CFG_MAX_PAYLOAD, {16'd0, maxp});
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        int              ph;
        int              len;
        int              pick;
        int              phase_start;
        logic [15:0]     maxp;
        logic [15:0]     seq;
        logic [SZ_W-1:0] sz;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset register values; a zero size field counts as one byte
        send_nalu_bytes(0, 1, '0, 32'hFFFF_FFFF, 8'hFF);

        // extreme registers: sequence wraps, one payload byte per fragment
        program_regs(7'd127, 32'hFFFF_FFFF, 16'hFFFF, 16'd4, CFG_UNUSED_LAST);
        send_nalu_bytes(0, 5, SZ_W'(5), 32'h0000_0000, 8'h7E);
        // nalu exactly at the payload limit stays a single packet
        send_nalu_bytes(0, 4, SZ_W'(4), 32'h89AB_CDEF, 8'h00);

        // registers rewritten in the middle of a fragmented nalu
        send_nalu_bytes(0, 4, SZ_W'(8), $urandom, 8'h26);
        program_regs(7'd0, 32'h0000_0000, 16'h1234, 16'd7, CFG_UNUSED_FIRST);
        send_nalu_bytes(4, 8, SZ_W'(8), $urandom, 8'h26);

        // largest payload limit
        program_regs(7'($urandom), $urandom, 16'($urandom), 16'hFFFF, CFG_UNUSED_FIRST);
        send_nalu_bytes(0, 3, SZ_W'(3), $urandom, 8'h40);

        // random phases over register settings and flow-control modes
        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       maxp = 16'd4;
                1:       maxp = 16'($urandom_range(5, 12));
                2:       maxp = 16'hFFFF;
                3:       maxp = 16'($urandom_range(4, 40));
                4:       maxp = 16'($urandom_range(13, 25));
                5:       maxp = 16'd4;
                6:       maxp = 16'($urandom_range(6, 16));
                default: maxp = hrtp_pkg::MAXP_RESET;
            endcase
            seq = (ph == 1) ? 16'd0 : 16'($urandom);
            program_regs(7'($urandom), $urandom, seq, maxp,
                         IDX_W'($urandom_range(4, 255)));
            case (ph % 4)
                0:
                begin
                    send_idle = 0;
                    recv_stall = 0;
                end
                1:
                begin
                    send_idle = 55;
                    recv_stall = 0;
                end
                2:
                begin
                    send_idle = 0;
                    recv_stall = 55;
                end
                default:
                begin
                    send_idle = 24;
                    recv_stall = 24;
                end
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
            begin
                // lengths around the single/fragment boundary, else random
                pick = $urandom_range(3);
                if (pick == 0)
                    len = int'(maxp);
                else if (pick == 1)
                    len = int'(maxp) + 1;
                else
                    len = $urandom_range(1, MAX_LEN);
                if (len > MAX_LEN)
                    len = $urandom_range(1, MAX_LEN);
                sz = SZ_W'(len);
                if (len == 1 && $urandom_range(3) == 0)
                    sz = '0;
                send_nalu_bytes(0, len, sz, $urandom, 8'($urandom));
            end
        end

        send_idle = 0;
        recv_stall = 0;
        settle();

        $display("summary: %0d nal bytes under %0d register settings, %0d rtp packets checked",
                 bytes_sent, settings_used, packets);
        $display("summary: flow control ran free, sender-idle, receiver-stall and mixed");
        if (errors == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
